// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the gain balance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define RCGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcgb: property failed");

// Concurrent assertion on the rising clock edge that also holds during reset.
`define RCGB_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rcgb: property failed");

`endif

// ----- design/rcgb_pkg.sv -----
// Types, constants and helper functions of the RGB channel gain balance block.
package rcgb_pkg;

  localparam int NCHAN          = 3;
  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 18;
  localparam int EFF_W          = 20;
  localparam int GAIN_FRAC_BITS = 16;

  // Luminance weights in Q16; they sum to 2^LW_W.
  localparam int LW_W        = 16;
  localparam int NORM_SHIFT  = 16 + GAIN_FRAC_BITS;
  localparam int S_W         = LW_W + GAIN_W;
  localparam int NUM_W       = GAIN_W + NORM_SHIFT + 1;
  localparam int HI_W        = NUM_W - EFF_W;
  localparam int CNT_W       = $clog2(EFF_W);
  localparam int K_W         = $clog2(NCHAN);
  localparam int PROD_W      = SAMPLE_W + EFF_W;
  localparam int SHR_W       = PROD_W - GAIN_FRAC_BITS;
  localparam int TDATA_W     = NCHAN * SAMPLE_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [EFF_W-1:0]    EFF_MAX    = '1;
  localparam logic [SAMPLE_W-1:0] LIMIT_8    = SAMPLE_W'(8'hFF);
  localparam logic [SAMPLE_W-1:0] LIMIT_16   = '1;

  localparam logic [LW_W-1:0] LW_RED   = LW_W'(19595);
  localparam logic [LW_W-1:0] LW_GREEN = LW_W'(38470);
  localparam logic [LW_W-1:0] LW_BLUE  = LW_W'(7471);

  localparam logic [K_W-1:0] CH_RED   = K_W'(0);
  localparam logic [K_W-1:0] CH_GREEN = K_W'(1);
  localparam logic [K_W-1:0] CH_BLUE  = K_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_RED      = 3'd0,
    REG_GAIN_GREEN    = 3'd1,
    REG_GAIN_BLUE     = 3'd2,
    REG_NORMALIZE     = 3'd3,
    REG_SAMPLE_DEPTH  = 3'd4,
    REG_CHANNEL_ORDER = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FILL,
    ST_LOAD,
    ST_DIV
  } norm_state_t;

  typedef logic [NCHAN-1:0][SAMPLE_W-1:0] pix_t;
  typedef logic [NCHAN-1:0][EFF_W-1:0]    eff_vec_t;

  typedef struct packed {
    logic [NCHAN-1:0][GAIN_W-1:0] gain;
    logic                         normalize;
    logic                         depth16;
    logic                         order_bgr;
  } cfg_t;

  function automatic logic [LW_W-1:0] luma_weight(input logic [K_W-1:0] k);
    logic [LW_W-1:0] w;
    unique case (k)
      CH_RED:   w = LW_RED;
      CH_GREEN: w = LW_GREEN;
      CH_BLUE:  w = LW_BLUE;
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- design/rcgb_norm.sv -----
// Effective gain sequencer: luminance sum and bit-serial normalising divide.
module rcgb_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rcgb_pkg::cfg_t    cfg,
  output logic              busy,
  output rcgb_pkg::eff_vec_t eff
);
  import rcgb_pkg::*;

  norm_state_t      state_r, state_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [S_W-1:0]   sum_r, sum_nxt;
  logic [S_W-1:0]   rem_r, rem_nxt;
  logic [EFF_W-1:0] lo_r, lo_nxt;
  logic [EFF_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  eff_vec_t         eff_r, eff_nxt;

  logic [S_W-1:0]   luma_term;
  logic [NUM_W-1:0] num;
  logic [HI_W-1:0]  hi;
  logic             hi_ovf;
  logic [S_W:0]     trial;
  logic [S_W:0]     diff;
  logic             ge;
  logic             last_k;
  logic             last_bit;
  logic             do_div;

  assign last_k    = (k_r == CH_BLUE);
  assign last_bit  = (cnt_r == CNT_W'(EFF_W - 1));
  assign do_div    = cfg.normalize && (sum_r != '0);
  assign luma_term = S_W'(luma_weight(k_r)) * S_W'(cfg.gain[k_r]);

  // Rounded numerator; if its upper part is not below the divisor the
  // quotient cannot fit and the gain saturates.
  assign num    = NUM_W'({cfg.gain[k_r], {NORM_SHIFT{1'b0}}}) + NUM_W'(sum_r >> 1);
  assign hi     = num[NUM_W-1:EFF_W];
  assign hi_ovf = (S_W'(hi) >= sum_r);

  assign trial = {rem_r, lo_r[EFF_W-1]};
  assign diff  = trial - {1'b0, sum_r};
  assign ge    = (trial >= {1'b0, sum_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SUM;
      ST_SUM:  if (last_k) state_nxt = ST_FILL;
      ST_FILL: state_nxt = do_div ? ST_LOAD : ST_IDLE;
      ST_LOAD: begin
        if (!hi_ovf) state_nxt = ST_DIV;
        else if (last_k) state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (last_bit) state_nxt = last_k ? ST_IDLE : ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    k_nxt   = k_r;
    sum_nxt = sum_r;
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    eff_nxt = eff_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sum_nxt = '0;
          k_nxt   = CH_RED;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_r + luma_term;
        k_nxt   = last_k ? CH_RED : k_r + K_W'(1);
      end
      ST_FILL: begin
        if (!do_div) begin
          for (int c = 0; c < NCHAN; c++) begin
            eff_nxt[c] = cfg.normalize ? '0 : EFF_W'(cfg.gain[c]);
          end
        end
      end
      ST_LOAD: begin
        if (hi_ovf) begin
          eff_nxt[k_r] = EFF_MAX;
          k_nxt        = last_k ? CH_RED : k_r + K_W'(1);
        end else begin
          rem_nxt = S_W'(hi);
          lo_nxt  = num[EFF_W-1:0];
          quo_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[S_W-1:0] : trial[S_W-1:0];
        lo_nxt  = lo_r << 1;
        quo_nxt = {quo_r[EFF_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_bit) begin
          eff_nxt[k_r] = {quo_r[EFF_W-2:0], ge};
          k_nxt        = last_k ? CH_RED : k_r + K_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= CH_RED;
      for (int c = 0; c < NCHAN; c++) begin
        eff_r[c] <= EFF_W'(GAIN_RESET);
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      eff_r   <= eff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign eff  = eff_r;

endmodule

// ----- design/rcgb_pipe.sv -----
// Three-stage pixel pipeline: gain select, multiply, shift and saturate.
module rcgb_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcgb_pkg::pix_t     in_pix,
  input  rcgb_pkg::cfg_t     cfg,
  input  rcgb_pkg::eff_vec_t eff,
  output logic               out_valid,
  input  logic               out_ready,
  output rcgb_pkg::pix_t     out_pix
);
  import rcgb_pkg::*;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic rdy1, rdy2, rdy3;

  pix_t     smp1_r, smp1_nxt;
  eff_vec_t gain1_r, gain1_nxt;
  logic     depth1_r, depth1_nxt;

  logic [NCHAN-1:0][PROD_W-1:0] prod2_r, prod2_nxt;
  logic                         depth2_r, depth2_nxt;

  pix_t out3_r, out3_nxt;

  logic [SAMPLE_W-1:0]  lim1;
  logic [SAMPLE_W-1:0]  lim2;
  logic [SHR_W-1:0]     shr [NCHAN];

  // Each stage takes a beat when it is empty or its content moves on.
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign lim1 = cfg.depth16 ? LIMIT_16 : LIMIT_8;
  assign lim2 = depth2_r ? LIMIT_16 : LIMIT_8;

  always_comb begin
    v1_nxt     = rdy1 ? in_valid : v1_r;
    smp1_nxt   = smp1_r;
    gain1_nxt  = gain1_r;
    depth1_nxt = depth1_r;
    if (rdy1 && in_valid) begin
      for (int c = 0; c < NCHAN; c++) begin
        smp1_nxt[c] = in_pix[c] & lim1;
      end
      gain1_nxt[CH_GREEN] = eff[CH_GREEN];
      gain1_nxt[CH_RED]   = cfg.order_bgr ? eff[CH_BLUE] : eff[CH_RED];
      gain1_nxt[CH_BLUE]  = cfg.order_bgr ? eff[CH_RED] : eff[CH_BLUE];
      depth1_nxt          = cfg.depth16;
    end
  end

  always_comb begin
    v2_nxt     = rdy2 ? v1_r : v2_r;
    prod2_nxt  = prod2_r;
    depth2_nxt = depth2_r;
    if (rdy2 && v1_r) begin
      for (int c = 0; c < NCHAN; c++) begin
        prod2_nxt[c] = PROD_W'(smp1_r[c]) * PROD_W'(gain1_r[c]);
      end
      depth2_nxt = depth1_r;
    end
  end

  always_comb begin
    v3_nxt   = rdy3 ? v2_r : v3_r;
    out3_nxt = out3_r;
    for (int c = 0; c < NCHAN; c++) begin
      shr[c] = prod2_r[c][PROD_W-1:GAIN_FRAC_BITS];
      if (rdy3 && v2_r) begin
        out3_nxt[c] = (shr[c] > SHR_W'(lim2)) ? lim2 : shr[c][SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp1_r   <= smp1_nxt;
    gain1_r  <= gain1_nxt;
    depth1_r <= depth1_nxt;
    prod2_r  <= prod2_nxt;
    depth2_r <= depth2_nxt;
    out3_r   <= out3_nxt;
  end

  assign in_ready  = rdy1;
  assign out_valid = v3_r;
  assign out_pix   = out3_r;

endmodule

// ----- design/rgb_channel_gain_balance.sv -----
// Top level of the RGB channel gain balance block: registers and glue.
//
// Pixels enter on the in_ stream, one beat per pixel, and leave on the out_
// stream in the same order with each colour sample scaled by its channel
// gain and saturated to 255 (8-bit depth) or 65535 (16-bit depth).
// The pixel path is three register stages deep, and a new pixel is taken
// every cycle while nothing stalls and the gain sequencer is idle.
// When out_tready is low the last stage holds its beat and the stages
// behind it keep filling until the pipe is full; only then does in_tready
// fall, and no beat is lost or repeated.
// Register writes on the cfg_ port restart the gain sequencer, which holds
// cfg_ready and in_tready low while it runs; with luminance normalisation
// its bit-serial divider produces one quotient bit per cycle for each gain
// that it divides.
// Reset (synchronous, active low) empties the pipe and returns all
// registers and effective gains to unity, 8-bit depth and red-first order.
module rgb_channel_gain_balance (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // chan_first [15:0], chan_middle [31:16], chan_last [47:32]
  input  logic [rcgb_pkg::TDATA_W-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_first [15:0], out_middle [31:16], out_last [47:32]
  output logic [rcgb_pkg::TDATA_W-1:0]    out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcgb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcgb_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  eff_vec_t eff;
  logic     busy;
  logic     cfg_acc;
  logic     pipe_rdy;
  pix_t     out_pix;

  assign cfg_ready = !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_acc) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_RED:      cfg_nxt.gain[CH_RED]   = cfg_data;
        REG_GAIN_GREEN:    cfg_nxt.gain[CH_GREEN] = cfg_data;
        REG_GAIN_BLUE:     cfg_nxt.gain[CH_BLUE]  = cfg_data;
        REG_NORMALIZE:     cfg_nxt.normalize      = cfg_data[0];
        REG_SAMPLE_DEPTH:  cfg_nxt.depth16        = cfg_data[0];
        REG_CHANNEL_ORDER: cfg_nxt.order_bgr      = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCHAN; c++) begin
        cfg_r.gain[c] <= GAIN_RESET;
      end
      cfg_r.normalize <= 1'b0;
      cfg_r.depth16   <= 1'b0;
      cfg_r.order_bgr <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcgb_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_acc),
    .cfg   (cfg_r),
    .busy  (busy),
    .eff   (eff)
  );

  // Pixels wait while the effective gains are being worked out.
  rcgb_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid && !busy),
    .in_ready  (pipe_rdy),
    .in_pix    (pix_t'(in_tdata)),
    .cfg       (cfg_r),
    .eff       (eff),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix)
  );

  assign in_tready = pipe_rdy && !busy;
  assign out_tdata = TDATA_W'(out_pix);

endmodule

// ----- design/rcgb_checker.sv -----
// Port-level checker for the RGB channel gain balance block, with its bind.
`include "assert_macros.svh"

module rcgb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [rcgb_pkg::TDATA_W-1:0]    in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rcgb_pkg::TDATA_W-1:0]    out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [rcgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rcgb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic in_beat;
  logic cfg_beat;

  assign in_beat  = in_tvalid && in_tready && (in_tdata == in_tdata);
  assign cfg_beat = cfg_valid && cfg_ready && (cfg_index == cfg_index)
                    && (cfg_data == cfg_data);

  // A stalled result beat keeps its data.
  `RCGB_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // After reset the pipe is empty and both inputs are open.
  `RCGB_ASSERT_ANY(a_reset_state, !rst_n |=> !out_tvalid && in_tready && cfg_ready)
  // A register write starts the gain sequencer, which closes both inputs.
  `RCGB_ASSERT(a_cfg_blocks, cfg_beat |=> !in_tready && !cfg_ready)
  // With the receiver ready, a pixel appears after three register stages.
  `RCGB_ASSERT(a_latency, in_beat ##1 out_tready ##1 out_tready |=> out_tvalid)

endmodule

bind rgb_channel_gain_balance rcgb_checker u_checker (.*);

// ----- tb/gain_balance_checker.sv -----
// Checker for the RGB channel gain balance block: predicts each result beat and compares it.
module gain_balance_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rcgb_pkg::TDATA_W-1:0]    in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rcgb_pkg::TDATA_W-1:0]    out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rcgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcgb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcgb_pkg::*;

  // Q16 luminance weights, summing to 65536.
  localparam logic [63:0] WEIGHT_RED   = 64'd19595;
  localparam logic [63:0] WEIGHT_GREEN = 64'd38470;
  localparam logic [63:0] WEIGHT_BLUE  = 64'd7471;
  localparam int          MAX_REPORTS  = 10;

  logic [GAIN_W-1:0] gain [NCHAN];
  logic [EFF_W-1:0]  eff_gain [NCHAN];
  logic              normalise;
  logic              depth16;
  logic              order_bgr;
  pix_t              scaled_due [$];
  int                mismatches = 0;
  int                due_count = 0;
  string             field_name [NCHAN] = '{"first", "middle", "last"};

  assign fail_count    = mismatches;
  assign pending_beats = due_count;

  function automatic void refresh_gains();
    logic [63:0] luma;
    logic [63:0] quot;
    luma = WEIGHT_RED * 64'(gain[CH_RED]) + WEIGHT_GREEN * 64'(gain[CH_GREEN])
         + WEIGHT_BLUE * 64'(gain[CH_BLUE]);
    for (int k = 0; k < NCHAN; k++) begin
      if (!normalise) begin
        eff_gain[k] = EFF_W'(gain[k]);
      end else if (luma == 64'd0) begin
        eff_gain[k] = '0;
      end else begin
        // Rounded to nearest, then held to the 20-bit range.
        quot = ((64'(gain[k]) << (16 + GAIN_FRAC_BITS)) + (luma >> 1)) / luma;
        eff_gain[k] = (quot > 64'hFFFFF) ? '1 : quot[EFF_W-1:0];
      end
    end
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_GAIN_RED:      gain[CH_RED] = value;
      REG_GAIN_GREEN:    gain[CH_GREEN] = value;
      REG_GAIN_BLUE:     gain[CH_BLUE] = value;
      REG_NORMALIZE:     normalise = value[0];
      REG_SAMPLE_DEPTH:  depth16 = value[0];
      REG_CHANNEL_ORDER: order_bgr = value[0];
      default:           return;
    endcase
    refresh_gains();
  endfunction

  function automatic logic [SAMPLE_W-1:0] apply_gain(logic [SAMPLE_W-1:0] sample,
                                                     logic [EFF_W-1:0] g);
    logic [SAMPLE_W-1:0] lim;
    logic [35:0]         prod;
    lim  = depth16 ? 16'hFFFF : 16'h00FF;
    // In 8-bit mode the upper byte of the sample never reaches the multiplier.
    prod = (36'(sample & lim) * 36'(g)) >> GAIN_FRAC_BITS;
    return (prod > 36'(lim)) ? lim : prod[SAMPLE_W-1:0];
  endfunction

  function automatic pix_t scaled_pixel(pix_t px);
    pix_t             res;
    logic [EFF_W-1:0] g_first;
    logic [EFF_W-1:0] g_last;
    g_first = order_bgr ? eff_gain[CH_BLUE] : eff_gain[CH_RED];
    g_last  = order_bgr ? eff_gain[CH_RED] : eff_gain[CH_BLUE];
    res[0] = apply_gain(px[0], g_first);
    res[1] = apply_gain(px[1], eff_gain[CH_GREEN]);
    res[2] = apply_gain(px[2], g_last);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pix_t got;
    pix_t want;
    bit   bad;
    if (!rst_n) begin
      for (int k = 0; k < NCHAN; k++) gain[k] = GAIN_RESET;
      normalise = 1'b0;
      depth16   = 1'b0;
      order_bgr = 1'b0;
      refresh_gains();
      scaled_due.delete();
    end else begin
      if (in_tvalid && in_tready) scaled_due.push_back(scaled_pixel(in_tdata));
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (scaled_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result beat %h arrived with nothing expected", $realtime, got);
          mismatches++;
        end else begin
          want = scaled_due.pop_front();
          bad  = 1'b0;
          for (int k = 0; k < NCHAN; k++) begin
            if (got[k] !== want[k]) begin
              bad = 1'b1;
              if (mismatches < MAX_REPORTS)
                $display("%0t: out_%s mismatch: expected %h, got %h",
                         $realtime, field_name[k], want[k], got[k]);
            end
          end
          if (bad) mismatches++;
        end
      end
    end
    due_count <= scaled_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the gain balance testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcgb_pkg::*;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_TESTS = 11;
  localparam int PRESSURE_AT  = 3;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_beats;
  int                    burst_left = 0;
  bit                    no_gaps = 1'b0;
  bit                    hold_off_req = 1'b0;

  rgb_channel_gain_balance dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gain_balance_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: stall pattern is redrawn at random after each run of random length; one long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int       left;
    mode = RX_OPEN;
    left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
          left = $urandom_range(16, 128);
        end
        left--;
        case (mode)
          RX_OPEN:     out_tready <= 1'b1;
          RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY:   out_tready <= ($urandom_range(0, 7) != 0);
          RX_PERIODIC: out_tready <= ((left % 6) < 2);
          default:     out_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic pix_t pixel(logic [15:0] first, logic [15:0] middle, logic [15:0] last);
    return {last, middle, first};
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 18'd65536;
      2:       return 18'd131072;
      3:       return '1;
      4:       return CFG_DATA_W'($urandom_range(0, 131072));
      5:       return CFG_DATA_W'($urandom_range(0, 262143));
      default: return CFG_DATA_W'($urandom_range(49152, 81920));
    endcase
  endfunction

  // The sender keeps tvalid high through a burst and drops it only for a real gap.
  task automatic send_pixel(pix_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic finish_phase();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // Each register is rewritten with a fair chance; flag registers get junk in the upper bits.
  task automatic shuffle_config();
    if ($urandom_range(0, 2) != 0) write_reg(REG_GAIN_RED, pick_gain());
    if ($urandom_range(0, 2) != 0) write_reg(REG_GAIN_GREEN, pick_gain());
    if ($urandom_range(0, 2) != 0) write_reg(REG_GAIN_BLUE, pick_gain());
    if ($urandom_range(0, 1) != 0) write_reg(REG_NORMALIZE, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1) != 0) write_reg(REG_SAMPLE_DEPTH, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1) != 0) write_reg(REG_CHANNEL_ORDER, CFG_DATA_W'($urandom));
    end_writes();
  endtask

  initial begin : stimulus
    int count;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unity gains, 8-bit samples, upper bytes must be dropped.
    send_pixel(pixel(16'h0000, 16'h0000, 16'h0000));
    send_pixel(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(16'h00FF, 16'h0100, 16'h01FF));
    send_pixel(pixel(16'h0001, 16'h0080, 16'h00FE));
    finish_phase();

    write_reg(REG_SAMPLE_DEPTH, 18'd1);
    end_writes();
    send_pixel(pixel(16'hFFFF, 16'h0000, 16'h8000));
    send_pixel(pixel(16'h1234, 16'hFFFF, 16'h0001));
    finish_phase();

    // Largest and zero gains with blue-first order; 16-bit saturation.
    write_reg(REG_GAIN_RED, '1);
    write_reg(REG_GAIN_GREEN, 18'd131072);
    write_reg(REG_GAIN_BLUE, '0);
    write_reg(REG_CHANNEL_ORDER, 18'd1);
    end_writes();
    send_pixel(pixel(16'hFFFF, 16'h8000, 16'h7FFF));
    send_pixel(pixel(16'h00FF, 16'h00FF, 16'h00FF));
    send_pixel(pixel(16'h0001, 16'h0001, 16'h0001));
    finish_phase();

    write_reg(REG_SAMPLE_DEPTH, 18'd0);
    end_writes();
    send_pixel(pixel(16'h00FF, 16'h0080, 16'hFF7F));
    finish_phase();

    // Zero luminance while normalising: every gain collapses to zero.
    write_reg(REG_GAIN_RED, '0);
    write_reg(REG_GAIN_GREEN, '0);
    write_reg(REG_NORMALIZE, 18'd1);
    end_writes();
    send_pixel(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(16'h0080, 16'h00FF, 16'h0001));
    finish_phase();

    write_reg(REG_GAIN_RED, 18'd65536);
    write_reg(REG_GAIN_GREEN, 18'd65536);
    write_reg(REG_GAIN_BLUE, 18'd65536);
    write_reg(REG_CHANNEL_ORDER, 18'd0);
    write_reg(REG_SAMPLE_DEPTH, 18'd1);
    end_writes();
    send_pixel(pixel(16'hFFFF, 16'h8001, 16'h0001));
    send_pixel(pixel(16'h1357, 16'h9BDF, 16'h2468));
    finish_phase();

    // Red alone normalised: the effective red gain lands far above unity.
    write_reg(REG_GAIN_RED, '1);
    write_reg(REG_GAIN_GREEN, '0);
    write_reg(REG_GAIN_BLUE, '0);
    end_writes();
    send_pixel(pixel(16'h7FFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(16'h0003, 16'h0003, 16'h0003));
    finish_phase();

    // Writes past the register list and junk above bit 0 of a flag.
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 18'h15555);
    write_reg(REG_NORMALIZE, 18'h3FFFE);
    end_writes();
    send_pixel(pixel(16'hFFFF, 16'h00FF, 16'h8000));
    send_pixel(pixel(16'h0100, 16'h0001, 16'hFFFE));
    finish_phase();

    for (int t = 0; t < RANDOM_TESTS; t++) begin
      shuffle_config();
      count = $urandom_range(35, 55);
      if (t == PRESSURE_AT) begin
        // Receiver blocks for a long stretch while beats keep coming, so the pipe fills.
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        burst_left   = 0;
        count        = 60;
      end
      repeat (count) send_pixel(pixel(pick_sample(), pick_sample(), pick_sample()));
      no_gaps = 1'b0;
      finish_phase();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
